FILE: rtl/ssa_pkg.sv
`timescale 1ns / 1ps

package ssa_pkg;

    localparam int FRAME_BITS = 10;
    localparam int CELL_BITS  = 12;
    localparam int COLS_BITS  = FRAME_BITS + 1;
    localparam int RECT_BITS  = FRAME_BITS + CELL_BITS;
    localparam int TIME_BITS  = 32;
    localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);
    localparam int IDX_BITS   = 3;
    localparam int CFG_BITS   = 32;

    // register indexes on the config port
    localparam logic [IDX_BITS-1:0] REG_START_FRAME   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_END_FRAME     = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_FRAME_DELAY   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_LOOP_ENABLE   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SHEET_COLUMNS = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_CELL_WIDTH    = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_CELL_HEIGHT   = 3'd6;

    // input actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [TIME_BITS-1:0]  elapsed_time;
        logic [FRAME_BITS-1:0] new_frame;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame_now;
        logic [RECT_BITS-1:0]  rect_left;
        logic [RECT_BITS-1:0]  rect_top;
        logic [RECT_BITS-1:0]  rect_right;
        logic [RECT_BITS-1:0]  rect_bottom;
        logic                  done_flag;
    } out_item_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] start_frame;
        logic [FRAME_BITS-1:0] end_frame;
        logic [TIME_BITS-1:0]  frame_delay;
        logic                  loop_enable;
        logic [COLS_BITS-1:0]  sheet_columns;
        logic [CELL_BITS-1:0]  cell_width;
        logic [CELL_BITS-1:0]  cell_height;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic last;
    } div_status_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_STEP  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL_L = 6'b010000,
        S_MUL_T = 6'b100000
    } state_t;

endpackage

FILE: rtl/ssa_cfg.sv
`timescale 1ns / 1ps

module ssa_cfg import ssa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_FRAME:   cfg_next.start_frame   = cfg_data[FRAME_BITS-1:0];
                REG_END_FRAME:     cfg_next.end_frame     = cfg_data[FRAME_BITS-1:0];
                REG_FRAME_DELAY:   cfg_next.frame_delay   = cfg_data[TIME_BITS-1:0];
                REG_LOOP_ENABLE:   cfg_next.loop_enable   = cfg_data[0];
                REG_SHEET_COLUMNS: cfg_next.sheet_columns = cfg_data[COLS_BITS-1:0];
                REG_CELL_WIDTH:    cfg_next.cell_width    = cfg_data[CELL_BITS-1:0];
                REG_CELL_HEIGHT:   cfg_next.cell_height   = cfg_data[CELL_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_frame   <= '0;
            cfg_reg.end_frame     <= '0;
            cfg_reg.frame_delay   <= TIME_BITS'(65536);
            cfg_reg.loop_enable   <= 1'b1;
            cfg_reg.sheet_columns <= COLS_BITS'(1);
            cfg_reg.cell_width    <= CELL_BITS'(2);
            cfg_reg.cell_height   <= CELL_BITS'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/ssa_div.sv
`timescale 1ns / 1ps

module ssa_div import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAME_BITS-1:0] dividend,
    input  logic [COLS_BITS-1:0]  divisor,
    output div_status_t           status,
    output logic [FRAME_BITS-1:0] quotient,
    output logic [COLS_BITS-1:0]  remainder
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic [FRAME_BITS-1:0] quo_reg;
    logic [FRAME_BITS-1:0] quo_next;
    logic [COLS_BITS-1:0]  rem_reg;
    logic [COLS_BITS-1:0]  rem_next;
    logic [COLS_BITS-1:0]  dsr_reg;
    logic [COLS_BITS-1:0]  dsr_next;
    logic [COLS_BITS:0]    trial;
    logic [COLS_BITS:0]    diff;
    logic                  fits;

    // restoring divide, one quotient bit per cycle, MSB first
    assign trial = {rem_reg, quo_reg[FRAME_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    assign status.busy = busy_reg;
    assign status.last = busy_reg && (cnt_reg == CNT_BITS'(1));
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(FRAME_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[COLS_BITS-1:0] : trial[COLS_BITS-1:0];
            quo_next  = {quo_reg[FRAME_BITS-2:0], fits};
            cnt_next  = cnt_reg - CNT_BITS'(1);
            busy_next = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

FILE: rtl/sprite_sheet_animator_core.sv
`timescale 1ns / 1ps
// An accepted input beat passes through the add, step, divide (one step per frame
// bit) and two multiply states before the result is registered into out_data; a
// stalled output holds the final state, and a new beat is taken only in idle.
// A finished result may wait in the output register while the next item is taken.
// Reset (rst_n, async, active low) clears frame, timer, done mark and all handshake
// state, and loads the config registers with their defaults.
module sprite_sheet_animator_core import ssa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_t cfg;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // captured input beat
    in_item_t item_reg;

    // animation state
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [TIME_BITS-1:0]  acc_reg;
    logic [TIME_BITS-1:0]  acc_next;
    logic                  complete_reg;
    logic                  complete_next;
    logic                  live_reg;      // tick with end frame above start frame
    logic                  live_next;

    // rectangle work register
    logic [RECT_BITS-1:0]  left_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_data_reg;
    out_item_t             result;

    // datapath
    logic                  in_fire;
    logic                  out_free;
    logic                  emit;
    logic [TIME_BITS:0]    sum_wide;
    logic [TIME_BITS-1:0]  sum_sat;
    logic [FRAME_BITS:0]   frame_inc;     // one bit wider: top frame + 1 leaves the range
    logic                  out_of_range;
    logic [COLS_BITS-1:0]  cols_eff;
    div_status_t           div_status;
    logic [FRAME_BITS-1:0] div_quo;
    logic [COLS_BITS-1:0]  div_rem;
    logic                  div_start;
    logic [FRAME_BITS-1:0] mul_a;
    logic [CELL_BITS-1:0]  mul_b;
    logic [RECT_BITS-1:0]  product;

    ssa_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // zero columns act as one
    assign cols_eff  = (cfg.sheet_columns == '0) ? COLS_BITS'(1) : cfg.sheet_columns;
    assign div_start = (state_reg == S_STEP);

    // the divider loads the frame as it leaves the step state, advance included
    ssa_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (frame_next),
        .divisor   (cols_eff),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    // final state holds until the output register can take the beat
    assign emit      = (state_reg == S_MUL_T) && out_free;

    // saturating timer add
    assign sum_wide = {1'b0, acc_reg} + {1'b0, item_reg.elapsed_time};
    assign sum_sat  = sum_wide[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_wide[TIME_BITS-1:0];

    assign frame_inc    = {1'b0, frame_reg} + (FRAME_BITS + 1)'(1);
    assign out_of_range = (frame_inc < {1'b0, cfg.start_frame})
                       || (frame_inc > {1'b0, cfg.end_frame});

    // one multiplier, shared: column * width first, then row * height
    assign mul_a   = (state_reg == S_MUL_L) ? div_rem[FRAME_BITS-1:0] : div_quo;
    assign mul_b   = (state_reg == S_MUL_L) ? cfg.cell_width : cfg.cell_height;
    assign product = RECT_BITS'(mul_a) * RECT_BITS'(mul_b);

    always_comb
    begin
        result.frame_now   = frame_reg;
        result.rect_left   = left_reg;
        result.rect_top    = product;
        result.rect_right  = left_reg + RECT_BITS'(cfg.cell_width);
        result.rect_bottom = product + RECT_BITS'(cfg.cell_height);
        result.done_flag   = complete_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        frame_next    = frame_reg;
        acc_next      = acc_reg;
        complete_next = complete_reg;
        live_next     = live_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                live_next = 1'b0;
                if (item_reg.action == ACT_SET)
                begin
                    frame_next    = item_reg.new_frame;
                    complete_next = 1'b0;
                end
                else if (cfg.end_frame > cfg.start_frame)
                begin
                    acc_next  = sum_sat;
                    live_next = 1'b1;
                end
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // frame advance; the divider takes frame_next at this edge
                state_next = S_DIV;
                if (live_reg && (acc_reg > cfg.frame_delay))
                begin
                    acc_next = acc_reg - cfg.frame_delay;
                    if (!out_of_range)
                    begin
                        frame_next = frame_inc[FRAME_BITS-1:0];
                    end
                    else if (cfg.loop_enable)
                    begin
                        frame_next = cfg.start_frame;
                    end
                    else
                    begin
                        frame_next    = cfg.end_frame;
                        complete_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_status.last)
                begin
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frame_reg     <= '0;
            acc_reg       <= '0;
            complete_reg  <= 1'b0;
            live_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            acc_reg       <= acc_next;
            complete_reg  <= complete_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_MUL_L)
        begin
            left_reg <= product;
        end
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    // --- checks ---

    // an accepted beat always starts the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_ADD))
        else $error("accepted beat did not start the sequence");

    // the divider is running for the whole divide phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> div_status.busy)
        else $error("divide phase without a busy divider");

    // remainder must be below the column count once the divide ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_L) |-> (div_rem < cols_eff))
        else $error("divider remainder not below column count");

    // a result beat is only loaded from the last sequence state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_MUL_T))
        else $error("result beat raised outside the final state");

endmodule
